### rtl/gcmg_pkg.sv
package gcmg_pkg;

	localparam int MAX_CELL_COLS = 64;
	localparam int GRAD_BITS     = 16;
	localparam int COORD_BITS    = 12;
	localparam int SLOT_W        = (MAX_CELL_COLS > 1) ? $clog2(MAX_CELL_COLS) : 1;
	localparam int IN_CELL_W     = 8;
	localparam int CELL_ROW_W    = 12;
	localparam int CELL_COL_W    = 6;
	localparam int OUT_DEPTH     = 3;

	localparam logic [11:0] IMAGE_ROWS_RST = 12'd480;
	localparam logic [11:0] IMAGE_COLS_RST = 12'd640;
	localparam logic [7:0]  CELL_ROWS_RST  = 8'd32;
	localparam logic [7:0]  CELL_COLS_RST  = 8'd32;

	typedef enum logic [1:0] {
		REG_IMAGE_ROWS,
		REG_IMAGE_COLS,
		REG_CELL_ROWS,
		REG_CELL_COLS
	} cfg_reg_t;

	typedef struct packed {
		logic                 frame_start;
		logic [7:0]           mask_byte;
		logic [GRAD_BITS-1:0] gradient;
	} pix_t;

	typedef struct packed {
		logic [CELL_ROW_W-1:0] cell_row_index;
		logic [CELL_COL_W-1:0] cell_col_index;
		logic                  has_point;
		logic [COORD_BITS-1:0] best_row;
		logic [COORD_BITS-1:0] best_col;
		logic [GRAD_BITS-1:0]  best_gradient;
		logic                  frame_done;
	} cell_t;

	typedef struct packed {
		logic                  any;
		logic [GRAD_BITS-1:0]  max;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
	} acc_t;

endpackage

### rtl/grid_cell_max_gradient_select.sv
// Grid-cell maximum-gradient selector. Pixels enter in raster order, one per clock, and the
// block sustains one pixel per cycle. Each pixel updates the accumulator of its cell column,
// held in a 64-entry single-port-write RAM with a registered read: the read is issued when the
// pixel is taken, the merged entry is written back in the following cycle, and a pixel of the same
// cell column taken on that write edge gets the new entry by forwarding. A cell result is
// written into the output queue on the clock edge after the cell's last pixel is taken and is
// valid on the output after any earlier results. Results drain through a three-entry queue;
// the pixel side stalls only when that queue backs up. The user must write size registers only
// while the block is idle, which the block does not enforce; a value of zero acts as one.
module grid_cell_max_gradient_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  gcmg_pkg::pix_t                pix,
	output logic                          cell_valid,
	input  logic                          cell_stall,
	output gcmg_pkg::cell_t               cell_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [11:0]                   cfg_data
);

	localparam int SW = gcmg_pkg::SLOT_W;
	localparam int CW = gcmg_pkg::COORD_BITS;
	localparam int IW = gcmg_pkg::IN_CELL_W;
	localparam int RW = gcmg_pkg::CELL_ROW_W;

	logic [11:0] image_rows_q, image_cols_q;
	logic [7:0]  cell_rows_q, cell_cols_q;

	logic [CW-1:0] pix_row_q, pix_col_q;
	logic [IW-1:0] in_cell_row_q, in_cell_col_q;
	logic [SW-1:0] cur_cell_col_q;
	logic [RW-1:0] cur_cell_row_q;

	logic          s1_valid_q;
	logic          s1_first;
	logic          s1_emit;
	logic          s1_frame_end;
	logic [7:0]    s1_mask;
	logic [gcmg_pkg::GRAD_BITS-1:0] s1_grad;
	logic [CW-1:0] s1_row, s1_col;
	logic [SW-1:0] s1_slot;
	logic [RW-1:0] s1_cell_row;
	logic          s1_fwd;
	gcmg_pkg::acc_t s1_fwd_acc;

	logic          accept;
	logic          fs;
	logic [CW-1:0] r_row, r_col;
	logic [IW-1:0] r_icr, r_icc;
	logic [SW-1:0] r_ccol;
	logic [RW-1:0] r_crow;
	logic [11:0]   ir_m1, ic_m1;
	logic [7:0]    cr_m1, cc_m1;
	logic          row_end, col_end, ccl, crl, fend;

	gcmg_pkg::acc_t ram_rdata, old_acc, new_acc;
	gcmg_pkg::cell_t res;

	gcmg_pkg::cell_t fifo_q [gcmg_pkg::OUT_DEPTH];
	logic [1:0]      rd_ptr_q, wr_ptr_q, cnt_q;
	logic            push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q <= gcmg_pkg::IMAGE_ROWS_RST;
			image_cols_q <= gcmg_pkg::IMAGE_COLS_RST;
			cell_rows_q  <= gcmg_pkg::CELL_ROWS_RST;
			cell_cols_q  <= gcmg_pkg::CELL_COLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gcmg_pkg::cfg_reg_t'(cfg_index))
				gcmg_pkg::REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				gcmg_pkg::REG_IMAGE_COLS: image_cols_q <= cfg_data;
				gcmg_pkg::REG_CELL_ROWS:  cell_rows_q  <= cfg_data[7:0];
				gcmg_pkg::REG_CELL_COLS:  cell_cols_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// position tracking, frame_start clears before use
	assign accept = pix_valid && !pix_stall;
	assign fs     = pix.frame_start;
	assign r_row  = fs ? '0 : pix_row_q;
	assign r_col  = fs ? '0 : pix_col_q;
	assign r_icr  = fs ? '0 : in_cell_row_q;
	assign r_icc  = fs ? '0 : in_cell_col_q;
	assign r_ccol = fs ? '0 : cur_cell_col_q;
	assign r_crow = fs ? '0 : cur_cell_row_q;

	assign ir_m1 = (image_rows_q == '0) ? '0 : image_rows_q - 12'd1;
	assign ic_m1 = (image_cols_q == '0) ? '0 : image_cols_q - 12'd1;
	assign cr_m1 = (cell_rows_q == '0) ? '0 : cell_rows_q - 8'd1;
	assign cc_m1 = (cell_cols_q == '0) ? '0 : cell_cols_q - 8'd1;

	assign row_end = 12'(r_col) >= ic_m1;
	assign col_end = 12'(r_row) >= ir_m1;
	assign ccl     = row_end || (r_icc >= cc_m1);
	assign crl     = col_end || (r_icr >= cr_m1);
	assign fend    = row_end && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_row_q      <= '0;
			pix_col_q      <= '0;
			in_cell_row_q  <= '0;
			in_cell_col_q  <= '0;
			cur_cell_col_q <= '0;
			cur_cell_row_q <= '0;
		end else if (accept) begin
			if (fend) begin
				pix_row_q      <= '0;
				pix_col_q      <= '0;
				in_cell_row_q  <= '0;
				in_cell_col_q  <= '0;
				cur_cell_col_q <= '0;
				cur_cell_row_q <= '0;
			end else if (row_end) begin
				pix_row_q      <= r_row + 1'b1;
				pix_col_q      <= '0;
				in_cell_col_q  <= '0;
				cur_cell_col_q <= '0;
				if (crl) begin
					in_cell_row_q  <= '0;
					cur_cell_row_q <= r_crow + 1'b1;
				end else begin
					in_cell_row_q  <= r_icr + 1'b1;
					cur_cell_row_q <= r_crow;
				end
			end else begin
				pix_row_q      <= r_row;
				pix_col_q      <= r_col + 1'b1;
				in_cell_row_q  <= r_icr;
				cur_cell_row_q <= r_crow;
				if (ccl) begin
					in_cell_col_q  <= '0;
					cur_cell_col_q <= (32'(r_ccol) == gcmg_pkg::MAX_CELL_COLS - 1) ?
						'0 : r_ccol + 1'b1;
				end else begin
					in_cell_col_q  <= r_icc + 1'b1;
					cur_cell_col_q <= r_ccol;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_first     <= (r_icr == '0) && (r_icc == '0);
			s1_emit      <= ccl && crl;
			s1_frame_end <= fend;
			s1_mask      <= pix.mask_byte;
			s1_grad      <= pix.gradient;
			s1_row       <= r_row;
			s1_col       <= r_col;
			s1_slot      <= r_ccol;
			s1_cell_row  <= r_crow;
			s1_fwd       <= s1_valid_q && (s1_slot == r_ccol);
			s1_fwd_acc   <= new_acc;
		end
	end

	gcmg_ram #(
		.WIDTH($bits(gcmg_pkg::acc_t)),
		.DEPTH(gcmg_pkg::MAX_CELL_COLS)
	) u_acc_ram (
		.clk  (clk),
		.we   (s1_valid_q),
		.waddr(s1_slot),
		.wdata(new_acc),
		.raddr(r_ccol),
		.rdata(ram_rdata)
	);

	// read-modify-write of the cell accumulator
	always_comb begin
		old_acc = s1_fwd ? s1_fwd_acc : ram_rdata;
		new_acc = old_acc;
		if (s1_first) begin
			new_acc.any = s1_mask != '0;
			new_acc.max = s1_grad;
			new_acc.row = s1_row;
			new_acc.col = s1_col;
		end else begin
			if (s1_mask != '0) begin
				new_acc.any = 1'b1;
			end
			if (s1_grad > old_acc.max) begin
				new_acc.max = s1_grad;
				new_acc.row = s1_row;
				new_acc.col = s1_col;
			end
		end
	end

	always_comb begin
		res.cell_row_index = s1_cell_row;
		res.cell_col_index = gcmg_pkg::CELL_COL_W'(s1_slot);
		res.has_point      = new_acc.any;
		res.best_row       = new_acc.row;
		res.best_col       = new_acc.col;
		res.best_gradient  = new_acc.max;
		res.frame_done     = s1_frame_end;
	end

	// result queue
	assign push       = s1_valid_q && s1_emit;
	assign pop        = cell_valid && !cell_stall;
	assign cell_valid = cnt_q != '0;
	assign cell_data  = fifo_q[rd_ptr_q];
	assign pix_stall  = ({1'b0, cnt_q} + {2'b00, push}) >= 3'(gcmg_pkg::OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == gcmg_pkg::OUT_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == gcmg_pkg::OUT_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= gcmg_pkg::OUT_DEPTH)
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> 32'(cnt_q) < gcmg_pkg::OUT_DEPTH)
		else $error("result pushed into full queue");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_frame_end) |->
			(pix_row_q == '0 && pix_col_q == '0 && cur_cell_row_q == '0))
		else $error("counters not cleared at frame end");

	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_fwd) |-> $past(s1_valid_q))
		else $error("forward without preceding write");

endmodule

### rtl/gcmg_ram.sv
module gcmg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
